// ===== hw/rtl/gbs_pkg.sv =====
// Shared types and constants for the greedy box suppression block.
// No dependencies.
package gbs_pkg;

    localparam int CORNER_W = 16;
    localparam int SCORE_W  = 16;
    localparam int LIMIT_W  = 16;
    localparam int INDEX_W  = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IOU_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_LIMIT = 2'd1;

    localparam logic [LIMIT_W-1:0] IOU_LIMIT_RST   = 16'd19661;
    localparam logic [LIMIT_W-1:0] SCORE_LIMIT_RST = 16'd39322;

    typedef struct packed {
        logic signed [CORNER_W-1:0] box_left;
        logic signed [CORNER_W-1:0] box_top;
        logic signed [CORNER_W-1:0] box_right;
        logic signed [CORNER_W-1:0] box_bottom;
        logic        [SCORE_W-1:0]  box_score;
        logic                       set_end;
    } t_box_in;

    typedef struct packed {
        logic [INDEX_W-1:0] kept_index;
        logic               none_kept;
        logic               truncated;
        logic               run_end;
    } t_result;

    typedef enum logic [1:0] {
        SW_INIT,
        SW_SELECT,
        SW_SUPP
    } t_sweep;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT_GO,
        S_INIT_WAIT,
        S_SEL_GO,
        S_SEL_WAIT,
        S_DECIDE,
        S_FETCH_RD,
        S_FETCH_LAT,
        S_FETCH_AREA,
        S_SUPP_GO,
        S_SUPP_WAIT
    } t_state;

    typedef struct packed {
        logic   load;
        logic   sweep_start;
        t_sweep kind;
        logic   fetch_rd;
        logic   fetch_lat;
        logic   fetch_area;
        logic   take;
        logic   push;
        logic   push_none;
        logic   push_trunc;
        logic   clr_set;
    } t_cmd;

    typedef struct packed {
        logic sweep_done;
        logic found;
        logic kept_full;
        logic held_any;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/gbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/gbs_datapath.sv =====
// Datapath: box stores, sweep engine, selection, IoU pipeline, result register.
// Depends on gbs_pkg and gbs_ram.
module gbs_datapath #(
    parameter int MAX_BOXES = 8192,
    parameter int MAX_KEPT  = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gbs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gbs_pkg::LIMIT_W-1:0]         i_cfg_data,
    input  gbs_pkg::t_box_in                    i_in,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output gbs_pkg::t_result                    o_out,
    input  gbs_pkg::t_cmd                       i_cmd,
    output gbs_pkg::t_stat                      o_stat
);
    import gbs_pkg::*;

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int KW = $clog2(MAX_KEPT + 1);

    logic [LIMIT_W-1:0] r_iou_lim, r_score_lim;
    logic [CW-1:0]      r_n;
    logic [KW-1:0]      r_emit;
    logic [IW-1:0]      r_held;

    logic               r_active;
    t_sweep             r_kind;
    logic [IW-1:0]      r_idx;
    logic               r_v1;
    logic [IW-1:0]      r_i1;

    logic               r_found;
    logic [IW-1:0]      r_best;
    logic [SCORE_W-1:0] r_best_score;

    logic [63:0]        r_a;
    logic signed [33:0] r_area_a;

    logic               r_out_valid;
    t_result            r_out;

    logic [63:0]        corner_rd;
    logic [SCORE_W-1:0] score_rd;
    logic               pend_rd;
    logic               store_we;
    logic               pend_we;
    logic [IW-1:0]      pend_waddr;
    logic               pend_wdata;
    logic               last_issue;

    assign store_we = i_cmd.load && (r_n < CW'(MAX_BOXES));

    gbs_ram #(.WIDTH(64), .DEPTH(MAX_BOXES)) u_corner_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_n[IW-1:0]),
        .i_wdata ({i_in.box_left, i_in.box_top, i_in.box_right, i_in.box_bottom}),
        .i_raddr (i_cmd.fetch_rd ? r_best : r_idx),
        .o_rdata (corner_rd)
    );

    gbs_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_BOXES)) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_n[IW-1:0]),
        .i_wdata (i_in.box_score),
        .i_raddr (r_idx),
        .o_rdata (score_rd)
    );

    gbs_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (pend_waddr),
        .i_wdata (pend_wdata),
        .i_raddr (r_idx),
        .o_rdata (pend_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iou_lim   <= IOU_LIMIT_RST;
            r_score_lim <= SCORE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IOU_LIMIT:   r_iou_lim   <= i_cfg_data;
                CFG_SCORE_LIMIT: r_score_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= '0;
            r_emit <= '0;
        end else if (i_cmd.clr_set) begin
            r_n    <= '0;
            r_emit <= '0;
        end else begin
            if (store_we) begin
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.take) begin
                r_emit <= r_emit + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_held <= r_best;
        end
    end

    // sweep issue
    assign last_issue = ((CW'(r_idx) + 1'b1) == r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_v1     <= 1'b0;
            r_kind   <= SW_INIT;
        end else begin
            r_v1 <= r_active;
            if (i_cmd.sweep_start) begin
                r_active <= 1'b1;
                r_kind   <= i_cmd.kind;
            end else if (r_active && last_issue) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1 <= r_idx;
        if (i_cmd.sweep_start) begin
            r_idx <= '0;
        end else if (r_active) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // selection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.sweep_start && i_cmd.kind == SW_SELECT) begin
            r_found <= 1'b0;
        end else if (r_v1 && r_kind == SW_SELECT && pend_rd
                     && (!r_found || score_rd > r_best_score)) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && r_kind == SW_SELECT && pend_rd && (!r_found || score_rd > r_best_score))
        begin
            r_best       <= r_i1;
            r_best_score <= score_rd;
        end
    end

    // taken box corners and area
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch_lat) begin
            r_a <= corner_rd;
        end
        if (i_cmd.fetch_area) begin
            r_area_a <= ($signed({r_a[31], r_a[31:16]}) - $signed({r_a[63], r_a[63:48]}))
                      * ($signed({r_a[15], r_a[15:0]}) - $signed({r_a[47], r_a[47:32]}));
        end
    end

    // IoU pipeline
    logic signed [CORNER_W-1:0] al, at, ar, ab, bl, bt, br, bb, x1, y1, x2, y2;
    logic signed [16:0]         w17, h17;
    logic [15:0]                w, h;

    assign al = r_a[63:48];
    assign at = r_a[47:32];
    assign ar = r_a[31:16];
    assign ab = r_a[15:0];
    assign bl = corner_rd[63:48];
    assign bt = corner_rd[47:32];
    assign br = corner_rd[31:16];
    assign bb = corner_rd[15:0];
    assign x1 = (al > bl) ? al : bl;
    assign y1 = (at > bt) ? at : bt;
    assign x2 = (ar < br) ? ar : br;
    assign y2 = (ab < bb) ? ab : bb;
    assign w17 = {x2[15], x2} - {x1[15], x1};
    assign h17 = {y2[15], y2} - {y1[15], y1};
    assign w = w17[16] ? 16'd0 : w17[15:0];
    assign h = h17[16] ? 16'd0 : h17[15:0];

    logic               r_v2, r_v3, r_v4, r_v5;
    logic               r_p2, r_p3, r_p4, r_p5;
    logic [IW-1:0]      r_i2, r_i3, r_i4, r_i5;
    logic [15:0]        r_w2, r_h2;
    logic signed [16:0] r_bw2, r_bh2;
    logic [31:0]        r_inter3, r_inter4;
    logic signed [33:0] r_area_b3;
    logic signed [35:0] r_uni4;
    logic [50:0]        r_prod5;
    logic [47:0]        r_inter5;
    logic               r_zero5, r_neg5;
    logic               survive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v2 <= r_v1 && r_kind == SW_SUPP;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2      <= pend_rd;
        r_i2      <= r_i1;
        r_w2      <= w;
        r_h2      <= h;
        r_bw2     <= {br[15], br} - {bl[15], bl};
        r_bh2     <= {bb[15], bb} - {bt[15], bt};
        r_p3      <= r_p2;
        r_i3      <= r_i2;
        r_inter3  <= r_w2 * r_h2;
        r_area_b3 <= r_bw2 * r_bh2;
        r_p4      <= r_p3;
        r_i4      <= r_i3;
        r_inter4  <= r_inter3;
        r_uni4    <= {{2{r_area_a[33]}}, r_area_a} + {{2{r_area_b3[33]}}, r_area_b3}
                   - $signed({4'b0, r_inter3});
        r_p5      <= r_p4;
        r_i5      <= r_i4;
        r_inter5  <= {r_inter4, 16'b0};
        r_zero5   <= (r_uni4 == '0);
        r_neg5    <= r_uni4[35];
        r_prod5   <= r_iou_lim * r_uni4[34:0];
    end

    assign survive = r_neg5 || (!r_zero5 && ({3'b0, r_inter5} <= r_prod5));

    always_comb begin
        pend_we    = 1'b0;
        pend_waddr = r_i1;
        pend_wdata = 1'b0;
        if (r_v1 && r_kind == SW_INIT) begin
            pend_we    = 1'b1;
            pend_wdata = (score_rd >= r_score_lim);
        end else if (r_v5) begin
            pend_we    = 1'b1;
            pend_waddr = r_i5;
            pend_wdata = r_p5 && survive && (r_i5 != r_best);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out.kept_index <= i_cmd.push_none ? '0 : INDEX_W'(r_held);
            r_out.none_kept  <= i_cmd.push_none;
            r_out.truncated  <= i_cmd.push_trunc;
            r_out.run_end    <= i_cmd.clr_set;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_stat.sweep_done = !r_active && !r_v1 && !r_v2 && !r_v3 && !r_v4 && !r_v5;
    assign o_stat.found      = r_found;
    assign o_stat.kept_full  = (r_emit == KW'(MAX_KEPT));
    assign o_stat.held_any   = (r_emit != '0);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
endmodule

// ===== hw/rtl/gbs_ctrl.sv =====
// Controller state machine: load, pending setup, select, fetch, suppress, emit.
// Depends on gbs_pkg.
module gbs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_set_end,
    output logic           o_in_stall,
    output gbs_pkg::t_cmd  o_cmd,
    input  gbs_pkg::t_stat i_stat
);
    import gbs_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:       if (i_in_valid && i_set_end) n_state = S_INIT_GO;
            S_INIT_GO:    n_state = S_INIT_WAIT;
            S_INIT_WAIT:  if (i_stat.sweep_done) n_state = S_SEL_GO;
            S_SEL_GO:     n_state = S_SEL_WAIT;
            S_SEL_WAIT:   if (i_stat.sweep_done) n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_stat.found && !i_stat.kept_full && !i_stat.held_any) begin
                    n_state = S_FETCH_RD;
                end else if (i_stat.out_free) begin
                    n_state = (i_stat.found && !i_stat.kept_full) ? S_FETCH_RD : S_LOAD;
                end
            end
            S_FETCH_RD:   n_state = S_FETCH_LAT;
            S_FETCH_LAT:  n_state = S_FETCH_AREA;
            S_FETCH_AREA: n_state = S_SUPP_GO;
            S_SUPP_GO:    n_state = S_SUPP_WAIT;
            S_SUPP_WAIT:  if (i_stat.sweep_done) n_state = S_SEL_GO;
            default:      n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = SW_INIT;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_LOAD: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_INIT_GO: begin
                o_cmd.sweep_start = 1'b1;
                o_cmd.kind        = SW_INIT;
            end
            S_SEL_GO: begin
                o_cmd.sweep_start = 1'b1;
                o_cmd.kind        = SW_SELECT;
            end
            S_SUPP_GO: begin
                o_cmd.sweep_start = 1'b1;
                o_cmd.kind        = SW_SUPP;
            end
            S_DECIDE: begin
                if (i_stat.found && !i_stat.kept_full) begin
                    if (!i_stat.held_any) begin
                        o_cmd.take = 1'b1;
                    end else if (i_stat.out_free) begin
                        o_cmd.take = 1'b1;
                        o_cmd.push = 1'b1;
                    end
                end else if (i_stat.out_free) begin
                    o_cmd.push       = 1'b1;
                    o_cmd.clr_set    = 1'b1;
                    o_cmd.push_none  = !i_stat.held_any;
                    o_cmd.push_trunc = i_stat.found;
                end
            end
            S_FETCH_RD:   o_cmd.fetch_rd   = 1'b1;
            S_FETCH_LAT:  o_cmd.fetch_lat  = 1'b1;
            S_FETCH_AREA: o_cmd.fetch_area = 1'b1;
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/greedy_box_suppression_top.sv =====
// Greedy box suppression: boxes load one per cycle; set_end starts the pass.
// Pass for n boxes: a pending setup sweep, then per kept box a select sweep and
// decide plus a fetch and an IoU pipeline sweep; a final select and decide ends
// the pass. Decide holds each result while the output stalls.
// Input stalls for the whole pass; sweeps read one box a cycle from the stores.
// Synchronous active-low reset clears control; box stores are not cleared.
module greedy_box_suppression_top #(
    parameter int MAX_BOXES = 8192,
    parameter int MAX_KEPT  = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gbs_pkg::LIMIT_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  gbs_pkg::t_box_in              i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output gbs_pkg::t_result              o_out
);
    import gbs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    gbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_set_end  (i_in.set_end),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    gbs_datapath #(.MAX_BOXES(MAX_BOXES), .MAX_KEPT(MAX_KEPT)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> stat.out_free) else $error("push into busy result register");

    a_sweep_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.sweep_start |-> stat.sweep_done) else $error("sweep started over another");

    a_take_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.take |-> (stat.found && !stat.kept_full)) else $error("take without room");
endmodule
